[rtl/aoc_pkg.sv]
// constants shared by the alpha-over compositor pipeline
// no dependencies
package aoc_pkg;

    localparam int unsigned OPACITY_FRAC_BITS = 8;
    localparam int unsigned CH_W              = 8;
    localparam int unsigned CH_MAX            = 255;
    localparam int unsigned MULT_W            = OPACITY_FRAC_BITS + 1;
    localparam int unsigned SCALE             = 1 << OPACITY_FRAC_BITS;

    // ao*mm and 255*S - ao*mm
    localparam int unsigned AM_W   = CH_W + MULT_W;
    // common denominator 255*255*S
    localparam int unsigned DEN    = CH_MAX * CH_MAX * SCALE;
    localparam int unsigned N_W    = $clog2(DEN + 1);
    localparam int unsigned ONE_AM = CH_MAX * SCALE;

    // blend numerator and divider widths
    localparam int unsigned SUM_W  = N_W + CH_W;
    localparam int unsigned X_W    = SUM_W + 2;
    localparam int unsigned Y_W    = N_W + 1;

    // alpha = floor((N + 255*S/2) / (255*S)), done as /S (a shift) then /255
    localparam int unsigned HALF_AM  = ONE_AM / 2;
    localparam int unsigned U_W      = N_W + 1 - OPACITY_FRAC_BITS;
    localparam int unsigned RECIP255 = 32'h8081;
    localparam int unsigned RECIP_SH = 23;
    localparam int unsigned APROD_W  = U_W + 16;

    localparam int unsigned NUM_CH = 3;

endpackage

[rtl/alpha_over_compositor.sv]
// alpha-over compositor, top level: full pipeline with a restoring divider
// depends on aoc_pkg
//
//  channel  | ports                                          | dir | beat marked by
//  ---------+------------------------------------------------+-----+---------------------
//  input    | back_pixel, front_pixel, opacity_multiplier    | in  | start high, busy low
//  result   | result_color                                   | out | done high, one cycle
//
// one pixel enters per clock; between start and done each pixel passes
// through four arithmetic stages, one setup stage, the
// eight stages of the quotient divider (one quotient bit per stage) and
// the output register
// busy never rises; rst_n clears all valid bits at once
// the receiver cannot stall, so results leave as soon as they are ready
module alpha_over_compositor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] back_pixel,
    input  logic [31:0] front_pixel,
    input  logic [8:0]  opacity_multiplier,
    output logic        done,
    output logic [31:0] result_color
);
    import aoc_pkg::*;

    localparam int unsigned QS = CH_W;

    // stage 1
    logic                v1_reg;
    logic [CH_W-1:0]     ab1_reg;
    logic [AM_W-1:0]     am1_reg;
    logic [CH_W-1:0]     cb1_reg [NUM_CH];
    logic [CH_W-1:0]     co1_reg [NUM_CH];
    // stage 2
    logic                v2_reg;
    logic [N_W-1:0]      p2_reg;
    logic [N_W-1:0]      pr2_reg;
    logic [CH_W-1:0]     cb2_reg [NUM_CH];
    logic [CH_W-1:0]     co2_reg [NUM_CH];
    // stage 3
    logic                v3_reg;
    logic [N_W-1:0]      n3_reg;
    logic [N_W-1:0]      p3_reg;
    logic [CH_W-1:0]     cb3_reg [NUM_CH];
    logic [CH_W-1:0]     co3_reg [NUM_CH];
    // stage 4
    logic                v4_reg;
    logic [N_W-1:0]      n4_reg;
    logic [APROD_W-1:0]  ap4_reg;
    logic [SUM_W-1:0]    ma4_reg [NUM_CH];
    logic [SUM_W-1:0]    mb4_reg [NUM_CH];
    // divider stages, index 0 is the setup stage
    logic                v_reg     [QS+1];
    logic                zero_reg  [QS+1];
    logic [CH_W-1:0]     alpha_reg [QS+1];
    logic [Y_W-1:0]      y_reg     [QS+1];
    logic [X_W-1:0]      rem_reg   [QS+1][NUM_CH];
    logic [CH_W-1:0]     q_reg     [QS+1][NUM_CH];
    // output
    logic                done_reg;
    logic [31:0]         res_reg;

    logic                accept;
    logic [MULT_W-1:0]   mm_sat;
    logic [AM_W-1:0]     inner;
    logic [N_W-1:0]      nmp;
    logic [U_W-1:0]      u_val;
    logic [31:0]         res_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign mm_sat = (opacity_multiplier > MULT_W'(SCALE)) ? MULT_W'(SCALE)
                                                          : opacity_multiplier;
    assign inner  = AM_W'(ONE_AM) - am1_reg;
    assign nmp    = n3_reg - p3_reg;
    assign u_val  = U_W'(((N_W+1)'(n3_reg) + (N_W+1)'(HALF_AM)) >> OPACITY_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int s = 0; s <= QS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v_reg[0] <= v4_reg;
            for (int s = 0; s < QS; s++)
            begin
                v_reg[s+1] <= v_reg[s];
            end
            done_reg <= v_reg[QS];
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: unpack, saturate, ao*mm
        ab1_reg <= back_pixel[31:24];
        am1_reg <= AM_W'(front_pixel[31:24]) * AM_W'(mm_sat);
        for (int c = 0; c < NUM_CH; c++)
        begin
            cb1_reg[c] <= back_pixel[c*CH_W +: CH_W];
            co1_reg[c] <= front_pixel[c*CH_W +: CH_W];
        end
        // stage 2: P and (255-ab)*(255*S - ao*mm)
        p2_reg  <= N_W'(am1_reg) * N_W'(CH_MAX);
        pr2_reg <= N_W'(CH_W'(CH_MAX) - ab1_reg) * N_W'(inner);
        cb2_reg <= cb1_reg;
        co2_reg <= co1_reg;
        // stage 3: N
        n3_reg  <= N_W'(DEN) - pr2_reg;
        p3_reg  <= p2_reg;
        cb3_reg <= cb2_reg;
        co3_reg <= co2_reg;
        // stage 4: channel products and alpha reciprocal product
        n4_reg  <= n3_reg;
        ap4_reg <= APROD_W'(u_val) * APROD_W'(RECIP255);
        for (int c = 0; c < NUM_CH; c++)
        begin
            ma4_reg[c] <= SUM_W'(cb3_reg[c]) * SUM_W'(nmp);
            mb4_reg[c] <= SUM_W'(co3_reg[c]) * SUM_W'(p3_reg);
        end
        // setup: dividend 2*num + N over divisor 2N
        zero_reg[0]  <= (n4_reg == '0);
        alpha_reg[0] <= ap4_reg[RECIP_SH +: CH_W];
        y_reg[0]     <= {n4_reg, 1'b0};
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem_reg[0][c] <= {(SUM_W+1)'(ma4_reg[c]) + (SUM_W+1)'(mb4_reg[c]), 1'b0}
                             + X_W'(n4_reg);
            q_reg[0][c]   <= '0;
        end
        // one quotient bit per stage, msb first
        for (int s = 0; s < QS; s++)
        begin
            zero_reg[s+1]  <= zero_reg[s];
            alpha_reg[s+1] <= alpha_reg[s];
            y_reg[s+1]     <= y_reg[s];
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (rem_reg[s][c] >= (X_W'(y_reg[s]) << (QS-1-s)))
                begin
                    rem_reg[s+1][c] <= rem_reg[s][c] - (X_W'(y_reg[s]) << (QS-1-s));
                    q_reg[s+1][c]   <= q_reg[s][c] | CH_W'(1 << (QS-1-s));
                end
                else
                begin
                    rem_reg[s+1][c] <= rem_reg[s][c];
                    q_reg[s+1][c]   <= q_reg[s][c];
                end
            end
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        if (zero_reg[QS])
        begin
            res_next = '0;
        end
        else
        begin
            res_next = {alpha_reg[QS], q_reg[QS][2], q_reg[QS][1], q_reg[QS][0]};
        end
    end

    assign done         = done_reg;
    assign result_color = res_reg;

    // a transparent pixel leaves as all zeros on the following clock
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[QS] && zero_reg[QS]) |=> (done && result_color == '0))
        else $error("transparent pixel not cleared");

    // the quotient fits in one channel: dividend below 256 divisors
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !zero_reg[0]) |->
            (rem_reg[0][0] < (X_W'(y_reg[0]) << QS) &&
             rem_reg[0][1] < (X_W'(y_reg[0]) << QS) &&
             rem_reg[0][2] < (X_W'(y_reg[0]) << QS)))
        else $error("blend quotient overflow");

endmodule

[sim/aoc_checker.sv]
// checker for the alpha-over compositor: watches input and result beats,
// predicts each composited pixel and compares in order; depends on aoc_pkg
`timescale 1ns / 100ps
module aoc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] back_pixel,
    input  logic [31:0] front_pixel,
    input  logic [8:0]  opacity_multiplier,
    input  logic        done,
    input  logic [31:0] result_color,
    output int          fail_count,
    output int          pending_count,
    output int          pixels_checked
);
    import aoc_pkg::*;

    logic [31:0] pixel_q[$];

    function automatic logic [31:0] composite_pixel(logic [31:0] bc, logic [31:0] oc,
                                                    logic [8:0] mult);
        longint unsigned s, mm, ab, ao, n, p, a, num, r;
        logic [31:0] res;
        s  = longint'(SCALE);
        mm = (mult > s) ? s : mult;
        ab = bc[31:24];
        ao = oc[31:24];
        n  = 255 * 255 * s - (255 - ab) * (255 * s - ao * mm);
        p  = 255 * ao * mm;
        if (n == 0)
            return 32'h0;
        a = (2 * n + 255 * s) / (2 * 255 * s);
        if (a > 255)
            a = 255;
        res[31:24] = a[7:0];
        for (int c = 0; c < NUM_CH; c++)
        begin
            num = longint'(bc[c*8 +: 8]) * (n - p) + longint'(oc[c*8 +: 8]) * p;
            r   = (2 * num + n) / (2 * n);
            if (r > 255)
                r = 255;
            res[c*8 +: 8] = r[7:0];
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            fail_count = 0;
            pixels_checked = 0;
            pixel_q.delete();
        end
        else
        begin
            if (done)
            begin
                pixels_checked++;
                if (pixel_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h", result_color);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (want !== result_color)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result_color mismatch: expected %h got %h",
                                     want, result_color);
                    end
                end
            end
            if (start && !busy)
                pixel_q.push_back(composite_pixel(back_pixel, front_pixel,
                                                  opacity_multiplier));
        end
        pending_count = pixel_q.size();
    end

endmodule

[sim/tb.sv]
// testbench top for alpha_over_compositor: directed and random pixels,
// idle phases, verdict; depends on aoc_pkg and aoc_checker
`timescale 1ns / 100ps
module tb;
    import aoc_pkg::*;

    localparam int WATCHDOG = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] back_pixel = '0;
    logic [31:0] front_pixel = '0;
    logic [8:0]  opacity_multiplier = '0;
    logic        done;
    logic [31:0] result_color;
    int          fail_count, pending_count, pixels_checked;
    int          idle_cycles = 0;
    int          idle_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    alpha_over_compositor u_dut (.*);

    aoc_checker u_chk (.*);

    always @(posedge clk)
    begin
        if (start && !busy || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one beat, random idles before it, waits until accepted
    task automatic send_pixel(logic [31:0] bc, logic [31:0] oc, logic [8:0] m);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        back_pixel <= bc;
        front_pixel <= oc;
        opacity_multiplier <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_alpha_pixel();
        logic [31:0] px;
        px = $urandom;
        case ($urandom_range(3, 0))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hff;
            default: ;
        endcase
        return px;
    endfunction

    function automatic logic [8:0] rand_mult();
        case ($urandom_range(4, 0))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'($urandom_range(511, 257));
            default: return 9'($urandom_range(256, 0));
        endcase
    endfunction

    initial
    begin
        int phase_pct[4];
        phase_pct = '{0, 65, 0, 8};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, saturation, fully transparent result
        send_pixel(32'h0000_0000, 32'h0000_0000, 9'd0);
        send_pixel(32'h00ff_ffff, 32'h00ff_ffff, 9'd256);
        send_pixel(32'h0012_3456, 32'hff65_4321, 9'd0);
        send_pixel(32'hffff_ffff, 32'hffff_ffff, 9'd511);
        send_pixel(32'hff00_0000, 32'hffff_ffff, 9'd256);
        send_pixel(32'hffff_ffff, 32'hff00_0000, 9'd257);
        send_pixel(32'h0000_0000, 32'hffff_ffff, 9'd1);
        send_pixel(32'h01ff_00ff, 32'h0100_ff00, 9'd128);
        send_pixel(32'h80aa_5500, 32'h8055_aaff, 9'd256);
        send_pixel(32'hffff_ffff, 32'h0000_0000, 9'd384);
        send_pixel(32'h00ff_ffff, 32'hff00_0000, 9'd255);
        send_pixel(32'h7f80_7f80, 32'h807f_807f, 9'd100);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_pct[ph];
            for (int i = 0; i < 225; i++)
                send_pixel(rand_alpha_pixel(), rand_alpha_pixel(), rand_mult());
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("composited %0d pixels over four idle phases, incl. saturated", pixels_checked);
        $display("multipliers and fully transparent pixels; %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
